// File: rtl/tsrb_pkg.sv
// ----------------------------------------------------------------------------
// tsrb_pkg
// Shared constants and codes for the timestamped sample ring buffer.
// ----------------------------------------------------------------------------
package tsrb_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int DEPTH_RST      = 64;

  localparam int TIME_W  = 64;
  localparam int PDATA_W = 32;
  localparam int DCFG_W  = 7;
  localparam int SEQ_W   = 7;
  localparam int MAXP_W  = 7;
  localparam int ACT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_LATEST = 2'd1,
    ACT_RECENT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage

// File: rtl/tsrb_ram.sv
// ----------------------------------------------------------------------------
// tsrb_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tsrb_ram
  import tsrb_pkg::*;
#(
  parameter int WIDTH  = TIME_W + DATA_WIDTH_DEF,
  parameter int DEPTH  = DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/timestamped_sample_ring_buffer.sv
// ----------------------------------------------------------------------------
// timestamped_sample_ring_buffer
// Overwriting ring of timestamped samples with latest and recent queries.
// ----------------------------------------------------------------------------
// A latest query reads the newest entry through the registered RAM read and then
// loads it into the output register once the result side is free. A recent query
// reads one stored entry per cycle through the one read port of the sample RAM,
// except while the result side stalls. Reset clears the control state and sets
// the depth to 64 (capped to DEPTH); the sample RAM is not cleared.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_buffer
  import tsrb_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DCFG_W-1:0]   cfg_depth_in_use,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [TIME_W-1:0]   in_point_time,
  input  logic [PDATA_W-1:0]  in_point_data,
  input  logic [TIME_W-1:0]   in_since_time,
  input  logic [MAXP_W-1:0]   in_max_points,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_point_valid,
  output logic [TIME_W-1:0]   out_time,
  output logic [PDATA_W-1:0]  out_data,
  output logic [SEQ_W-1:0]    out_sequence_res,
  output logic                out_is_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = TIME_W + DATA_WIDTH;
  localparam logic [CW-1:0] DEPTH_MAX = CW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_RST_C = (DEPTH_RST > DEPTH) ? CW'(DEPTH) : CW'(DEPTH_RST);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LATEST = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINAL  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       depth_r, depth_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic [SEQ_W-1:0]    n_r, n_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [TIME_W-1:0]   pend_time_r, pend_time_nxt;
  logic [PDATA_W-1:0]  pend_data_r, pend_data_nxt;
  logic [TIME_W-1:0]   since_r, since_nxt;
  logic [MAXP_W-1:0]   maxp_r, maxp_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_pv_r, out_pv_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic [PDATA_W-1:0]  out_data_r, out_data_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [MW-1:0]       ram_wdata, ram_rdata;
  logic [TIME_W-1:0]   pd_ext, rd_dext, rd_time;
  logic [CW-1:0]       cfg_dep;
  logic [CW:0]         start_sum, start_adj;
  logic [AW-1:0]       start_idx, latest_idx;
  logic                out_free, match, stall, done;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a, input logic [CW-1:0] d);
    logic [CW:0] a1;
    a1 = (CW+1)'(a) + (CW+1)'(1);
    wrap_inc = (a1 == (CW+1)'(d)) ? '0 : AW'(a1);
  endfunction

  tsrb_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stored data is kept at DATA_WIDTH bits and shown zero-extended or cut to the port.
  assign pd_ext    = TIME_W'(in_point_data);
  assign ram_wdata = {in_point_time, pd_ext[DATA_WIDTH-1:0]};
  assign rd_time   = ram_rdata[MW-1:DATA_WIDTH];
  assign rd_dext   = TIME_W'(ram_rdata[DATA_WIDTH-1:0]);

  always_comb begin
    if (cfg_depth_in_use == '0) begin
      cfg_dep = CW'(1);
    end else if (32'(cfg_depth_in_use) > 32'(DEPTH)) begin
      cfg_dep = DEPTH_MAX;
    end else begin
      cfg_dep = CW'(cfg_depth_in_use);
    end
  end

  // The oldest entry sits fill_count places behind the write position.
  always_comb begin
    start_sum = (CW+1)'(wp_r) + (CW+1)'(depth_r) - (CW+1)'(fill_r);
    start_adj = (start_sum >= (CW+1)'(depth_r)) ? start_sum - (CW+1)'(depth_r) : start_sum;
    start_idx = AW'(start_adj);
    latest_idx = (wp_r == '0) ? AW'(depth_r - CW'(1)) : wp_r - AW'(1);
  end

  assign out_free = !out_valid_r || out_ready;
  assign match    = $signed(rd_time) >= $signed(since_r);
  // A second match cannot be taken while the held one still has nowhere to go.
  assign stall    = match && pend_v_r && !out_free;
  assign done     = (iss_r == fill_r) ||
                    (match && ((SEQ_W+1)'(n_r) + (SEQ_W+1)'(1) == (SEQ_W+1)'(maxp_r)));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    iss_nxt       = iss_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_time_nxt = pend_time_r;
    pend_data_nxt = pend_data_r;
    since_nxt     = since_r;
    maxp_nxt      = maxp_r;
    out_valid_nxt = out_valid_r;
    out_pv_nxt    = out_pv_r;
    out_time_nxt  = out_time_r;
    out_data_nxt  = out_data_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      depth_nxt = cfg_dep;
      wp_nxt    = '0;
      fill_nxt  = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (action_t'(in_action))
            ACT_PUSH: begin
              ram_we = 1'b1;
              wp_nxt = wrap_inc(wp_r, depth_r);
              if (fill_r < depth_r) begin
                fill_nxt = fill_r + CW'(1);
              end
            end
            ACT_LATEST: begin
              ram_re    = (fill_r != '0);
              ram_raddr = latest_idx;
              state_nxt = S_LATEST;
            end
            ACT_RECENT: begin
              since_nxt  = in_since_time;
              maxp_nxt   = in_max_points;
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              if (fill_r == '0 || in_max_points == '0) begin
                state_nxt = S_FINAL;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = start_idx;
                rd_idx_nxt = wrap_inc(start_idx, depth_r);
                iss_nxt    = CW'(1);
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LATEST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (fill_r != '0) begin
            out_pv_nxt   = 1'b1;
            out_time_nxt = rd_time;
            out_data_nxt = rd_dext[PDATA_W-1:0];
            out_seq_nxt  = SEQ_W'(1);
          end else begin
            out_pv_nxt   = 1'b0;
            out_time_nxt = '0;
            out_data_nxt = '0;
            out_seq_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // The newest match is held back until the next one shows it was not the last.
        if (!stall) begin
          if (match) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_pv_nxt    = 1'b1;
              out_time_nxt  = pend_time_r;
              out_data_nxt  = pend_data_r;
              out_seq_nxt   = n_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_time_nxt = rd_time;
            pend_data_nxt = rd_dext[PDATA_W-1:0];
            n_nxt         = n_r + SEQ_W'(1);
          end
          if (done) begin
            state_nxt = S_FINAL;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = rd_idx_r;
            rd_idx_nxt = wrap_inc(rd_idx_r, depth_r);
            iss_nxt    = iss_r + CW'(1);
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_pv_nxt    = pend_v_r;
          out_time_nxt  = pend_v_r ? pend_time_r : '0;
          out_data_nxt  = pend_v_r ? pend_data_r : '0;
          out_seq_nxt   = pend_v_r ? n_r : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= DEPTH_RST_C;
      wp_r        <= '0;
      fill_r      <= '0;
      iss_r       <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      iss_r       <= iss_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    pend_time_r <= pend_time_nxt;
    pend_data_r <= pend_data_nxt;
    since_r     <= since_nxt;
    maxp_r      <= maxp_nxt;
    out_pv_r    <= out_pv_nxt;
    out_time_r  <= out_time_nxt;
    out_data_r  <= out_data_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_point_valid  = out_pv_r;
  assign out_time         = out_time_r;
  assign out_data         = out_data_r;
  assign out_sequence_res = out_seq_r;
  assign out_is_last      = out_last_r;

  a_fill_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= depth_r)
    else $error("fill count exceeds depth in use");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(wp_r) < (CW+1)'(depth_r))
    else $error("write position outside the ring");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r != '0 && iss_r <= fill_r))
    else $error("scan read count out of range");

  a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((SEQ_W+1)'(n_r) < (SEQ_W+1)'(maxp_r)))
    else $error("scan went past its point limit");

  a_pend_seq: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (n_r != '0))
    else $error("held sample without a sequence number");

endmodule
